/* rtl/core/mrpf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Mie repulsive pair force: shared package
// Types, register codes and fixed constants used by the pair force datapath.
// ----------------------------------------------------------------------------
package mrpf_pkg;

  typedef enum logic [1:0] {
    KIND_MIE_4_2  = 2'd0,
    KIND_MIE_6_2  = 2'd1,
    KIND_MIE_8_4  = 2'd2,
    KIND_MIE_12_6 = 2'd3
  } kind_t;

  localparam logic [1:0] REG_KIND   = 2'd0;
  localparam logic [1:0] REG_CUTOFF = 2'd1;
  localparam logic [1:0] REG_SPRING = 2'd2;

  localparam int MUL_LAT = 4;

  // Scale constants in Q0.32, rounded to the working format at elaboration.
  localparam logic [31:0] C_F42  = 32'd858993459;
  localparam logic [31:0] C_F62  = 32'd334749751;
  localparam logic [31:0] C_F84  = 32'd68719477;
  localparam logic [31:0] C_E84  = 32'd17179869;
  localparam logic [31:0] C_F126 = 32'd371085174;
  localparam logic [31:0] C_E126 = 32'd61847529;

  localparam logic [63:0] W_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [15:0]        idx_i;
    logic [15:0]        idx_j;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic               in_range;
  } side_t;

  function automatic logic signed [63:0] q32_to_q(input logic [31:0] c, input int frac);
    logic [33:0] sum;
    begin
      sum = {2'b00, c} + (34'd1 << (31 - frac));
      q32_to_q = {30'b0, (sum >> (32 - frac))};
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    begin
      if ((v[63:31] == '0) || (v[63:31] == '1)) begin
        sat32 = v[31:0];
      end else if (v[63]) begin
        sat32 = 32'sh8000_0000;
      end else begin
        sat32 = 32'sh7FFF_FFFF;
      end
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/core/mrpf_mulq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Mie repulsive pair force: saturating fixed-point multiplier
// Four-stage signed multiply of two 64-bit values built from 32x32 partial
// products; the magnitude is truncated to the fraction width and saturated.
// ----------------------------------------------------------------------------
module mrpf_mulq #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);
  import mrpf_pkg::*;

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg1;
  logic [63:0]  p00;
  logic [63:0]  p01;
  logic [63:0]  p10;
  logic [63:0]  p11;
  logic         neg2;
  logic [63:0]  lo;
  logic [63:0]  hi;
  logic         neg3;
  logic [33:0]  mid;
  logic [63:0]  hi_sum;
  logic [127:0] full;
  logic [63:0]  rr;
  logic         over;
  logic [63:0]  mag_sat;
  logic [63:0]  p_next;

  always_comb begin
    mid     = 34'(p00[63:32]) + 34'(p01[31:0]) + 34'(p10[31:0]);
    hi_sum  = p11 + 64'(p01[63:32]) + 64'(p10[63:32]) + 64'(mid[33:32]);
    full    = {hi, lo};
    rr      = full[FRAC_BITS +: 64];
    over    = ((hi >> FRAC_BITS) != '0) || rr[63];
    mag_sat = over ? W_MAX : rr;
    p_next  = neg3 ? 64'(-mag_sat) : mag_sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= a[63] ? 64'(-a) : 64'(a);
      mb   <= b[63] ? 64'(-b) : 64'(b);
      neg1 <= a[63] ^ b[63];
      p00  <= 64'(ma[31:0]) * 64'(mb[31:0]);
      p01  <= 64'(ma[31:0]) * 64'(mb[63:32]);
      p10  <= 64'(ma[63:32]) * 64'(mb[31:0]);
      p11  <= 64'(ma[63:32]) * 64'(mb[63:32]);
      neg2 <= neg1;
      lo   <= {mid[31:0], p00[31:0]};
      hi   <= hi_sum;
      neg3 <= neg2;
      p    <= $signed(p_next);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mie_repulsive_pair_force.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Mie repulsive pair force
// Streams particle pairs and returns the truncated repulsive Mie force on
// particle i and the pair energy, in saturated signed fixed point.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                | Words
//  ---------+--------------------------+-------------------------------------
//  pair in  | in_valid / in_stall      | indices, two positions, sigma_sq
//  force out| out_valid / out_stall    | indices, force x/y/z, energy, flag
//  config   | wr_en / wr_index         | wr_data to kind, cutoff, spring
//
// One pair enters per cycle while the output is not stalled; the divider
// resolves one quotient bit per stage.
// Reset clears the valid bits and loads the register reset values.
// A stalled output word freezes the whole pipeline and raises in_stall.
// ----------------------------------------------------------------------------
module mie_repulsive_pair_force #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        index_i,
  input  logic [15:0]        index_j,
  input  logic signed [31:0] pos_i_x,
  input  logic signed [31:0] pos_i_y,
  input  logic signed [31:0] pos_i_z,
  input  logic signed [31:0] pos_j_x,
  input  logic signed [31:0] pos_j_y,
  input  logic signed [31:0] pos_j_z,
  input  logic [31:0]        sigma_sq,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_index_i,
  output logic [15:0]        out_index_j,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic signed [31:0] force_z,
  output logic signed [31:0] pair_energy,
  output logic               in_range
);
  import mrpf_pkg::*;

  localparam int L         = MUL_LAT;
  localparam int NUM_W     = 32 + FRAC_BITS;
  localparam int RANGE_STG = 4;
  localparam int DIV_OUT   = RANGE_STG + NUM_W;
  localparam int FM_STG    = DIV_OUT + 6 * L + 1;
  localparam int FRC_STG   = DIV_OUT + 7 * L + 1;
  localparam int OUT_STG   = FRC_STG + 1;

  localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] QF42  = q32_to_q(C_F42, FRAC_BITS);
  localparam logic signed [63:0] QF62  = q32_to_q(C_F62, FRAC_BITS);
  localparam logic signed [63:0] QF84  = q32_to_q(C_F84, FRAC_BITS);
  localparam logic signed [63:0] QE84  = q32_to_q(C_E84, FRAC_BITS);
  localparam logic signed [63:0] QF126 = q32_to_q(C_F126, FRAC_BITS);
  localparam logic signed [63:0] QE126 = q32_to_q(C_E126, FRAC_BITS);

  logic [1:0]  kind_reg;
  logic [31:0] cutoff_reg;
  logic [31:0] spring_reg;
  kind_t       kind;

  logic adv;
  logic [OUT_STG:0] vld;
  side_t side [0:FRC_STG];

  logic [31:0] sig_d [0:3];
  logic [32:0] mag_r [0:2];
  logic [65:0] sq_r  [0:2];
  logic [63:0] rsq_r;
  logic [66:0] rsq_sum;
  logic        rq_zero;

  logic [31:0]      d_q  [0:NUM_W];
  logic [31:0]      rs   [0:NUM_W];
  logic [NUM_W-1:0] qs   [0:NUM_W];
  logic [31:0]      rr   [0:NUM_W];
  logic [NUM_W-1:0] qr   [0:NUM_W];
  logic [32:0]      shs  [0:NUM_W-1];
  logic [32:0]      shr  [0:NUM_W-1];
  logic [NUM_W-1:0] ges;
  logic [NUM_W-1:0] ger;
  logic [31:0]      rs_next [0:NUM_W-1];
  logic [31:0]      rr_next [0:NUM_W-1];

  logic signed [63:0] s_val;
  logic signed [63:0] r2_val;
  logic signed [63:0] s_d  [1:2*L];
  logic signed [63:0] q1_d [1:L];
  logic signed [63:0] r2_d [1:5*L+1];
  logic signed [63:0] en_d [1:2*L];

  logic signed [63:0] q1;
  logic signed [63:0] q3;
  logic signed [63:0] t_sel;
  logic signed [63:0] a_sel;
  logic [66:0]        mlt;
  logic [63:0]        mlt_sat;
  logic signed [63:0] ft_next;
  logic signed [63:0] et_next;
  logic signed [63:0] a_r;
  logic signed [63:0] ft_r;
  logic signed [63:0] et_r;
  logic signed [63:0] cf;
  logic signed [63:0] ce;
  logic signed [63:0] spring_k64;

  logic signed [63:0] pf;
  logic signed [63:0] pe;
  logic signed [63:0] pfc;
  logic signed [63:0] pec;
  logic signed [63:0] fk;
  logic signed [63:0] ek;
  logic signed [63:0] fm;
  logic signed [63:0] fx;
  logic signed [63:0] fy;
  logic signed [63:0] fz;

  assign kind       = kind_t'(kind_reg);
  assign spring_k64 = $signed({32'b0, spring_reg});
  assign out_valid  = vld[OUT_STG];
  assign in_stall   = out_valid && out_stall;
  assign adv        = !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind_reg   <= KIND_MIE_4_2;
      cutoff_reg <= 32'd65536;
      spring_reg <= 32'd65536;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_KIND:   kind_reg   <= wr_data[1:0];
        REG_CUTOFF: cutoff_reg <= wr_data;
        REG_SPRING: spring_reg <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[OUT_STG-1:0], in_valid};
    end
  end

  always_comb begin
    rsq_sum = 67'(sq_r[0]) + 67'(sq_r[1]) + 67'(sq_r[2]);
    rq_zero = (rsq_r >> FRAC_BITS) == '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0].idx_i    <= index_i;
      side[0].idx_j    <= index_j;
      side[0].dx       <= 33'(pos_i_x) - 33'(pos_j_x);
      side[0].dy       <= 33'(pos_i_y) - 33'(pos_j_y);
      side[0].dz       <= 33'(pos_i_z) - 33'(pos_j_z);
      side[0].in_range <= 1'b0;
      for (int k = 1; k <= FRC_STG; k++) begin
        if (k != RANGE_STG) begin
          side[k] <= side[k-1];
        end
      end
      side[RANGE_STG].idx_i    <= side[RANGE_STG-1].idx_i;
      side[RANGE_STG].idx_j    <= side[RANGE_STG-1].idx_j;
      side[RANGE_STG].dx       <= side[RANGE_STG-1].dx;
      side[RANGE_STG].dy       <= side[RANGE_STG-1].dy;
      side[RANGE_STG].dz       <= side[RANGE_STG-1].dz;
      side[RANGE_STG].in_range <=
        rsq_r <= {{(32 - FRAC_BITS){1'b0}}, cutoff_reg, {FRAC_BITS{1'b0}}};

      sig_d[0] <= sigma_sq;
      for (int k = 1; k < 4; k++) begin
        sig_d[k] <= sig_d[k-1];
      end
      mag_r[0] <= side[0].dx[32] ? 33'(-side[0].dx) : 33'(side[0].dx);
      mag_r[1] <= side[0].dy[32] ? 33'(-side[0].dy) : 33'(side[0].dy);
      mag_r[2] <= side[0].dz[32] ? 33'(-side[0].dz) : 33'(side[0].dz);
      for (int c = 0; c < 3; c++) begin
        sq_r[c] <= 66'(mag_r[c]) * 66'(mag_r[c]);
      end
      rsq_r <= (rsq_sum[66:64] != '0) ? '1 : rsq_sum[63:0];

      d_q[0] <= rq_zero ? 32'd1 : rsq_r[FRAC_BITS +: 32];
      rs[0]  <= '0;
      qs[0]  <= {sig_d[3], {FRAC_BITS{1'b0}}};
      rr[0]  <= '0;
      qr[0]  <= NUM_W'(1) << (2 * FRAC_BITS);
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_W; j++) begin
      shs[j]     = {rs[j], qs[j][NUM_W-1]};
      shr[j]     = {rr[j], qr[j][NUM_W-1]};
      ges[j]     = shs[j] >= {1'b0, d_q[j]};
      ger[j]     = shr[j] >= {1'b0, d_q[j]};
      rs_next[j] = ges[j] ? 32'(shs[j] - {1'b0, d_q[j]}) : shs[j][31:0];
      rr_next[j] = ger[j] ? 32'(shr[j] - {1'b0, d_q[j]}) : shr[j][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NUM_W; j++) begin
        d_q[j+1] <= d_q[j];
        rs[j+1]  <= rs_next[j];
        qs[j+1]  <= {qs[j][NUM_W-2:0], ges[j]};
        rr[j+1]  <= rr_next[j];
        qr[j+1]  <= {qr[j][NUM_W-2:0], ger[j]};
      end
    end
  end

  assign s_val  = $signed(64'(qs[NUM_W]));
  assign r2_val = $signed(64'(qr[NUM_W]));

  mrpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_q1 (
    .clk(clk), .en(adv), .a(s_val), .b(s_val), .p(q1));
  mrpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_q3 (
    .clk(clk), .en(adv), .a(q1), .b(s_d[L]), .p(q3));

  always_comb begin
    unique case (kind)
      KIND_MIE_4_2: begin
        t_sel = s_d[2*L];
        a_sel = s_d[2*L];
        mlt   = {3'b0, t_sel} << 2;
        cf    = QF42;
        ce    = QF42;
      end
      KIND_MIE_6_2: begin
        t_sel = q1_d[L];
        a_sel = s_d[2*L];
        mlt   = ({3'b0, t_sel} << 2) + ({3'b0, t_sel} << 1);
        cf    = QF62;
        ce    = QF62;
      end
      KIND_MIE_8_4: begin
        t_sel = q1_d[L];
        a_sel = q1_d[L];
        mlt   = {3'b0, t_sel} << 1;
        cf    = QF84;
        ce    = QE84;
      end
      default: begin
        t_sel = q3;
        a_sel = q3;
        mlt   = {3'b0, t_sel} << 1;
        cf    = QF126;
        ce    = QE126;
      end
    endcase
    mlt_sat = (mlt > 67'(W_MAX)) ? W_MAX : mlt[63:0];
    if (kind == KIND_MIE_4_2 || kind == KIND_MIE_6_2) begin
      ft_next = $signed(mlt_sat) - (ONE <<< 1);
    end else begin
      ft_next = $signed(mlt_sat) - ONE;
    end
    et_next = t_sel - ONE;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_d[1]  <= s_val;
      q1_d[1] <= q1;
      r2_d[1] <= r2_val;
      en_d[1] <= ek;
      for (int k = 2; k <= 2 * L; k++) begin
        s_d[k]  <= s_d[k-1];
        en_d[k] <= en_d[k-1];
      end
      for (int k = 2; k <= L; k++) begin
        q1_d[k] <= q1_d[k-1];
      end
      for (int k = 2; k <= 5 * L + 1; k++) begin
        r2_d[k] <= r2_d[k-1];
      end
      a_r  <= a_sel;
      ft_r <= ft_next;
      et_r <= et_next;
    end
  end

  mrpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_pf (
    .clk(clk), .en(adv), .a(a_r), .b(ft_r), .p(pf));
  mrpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_pe (
    .clk(clk), .en(adv), .a(a_r), .b(et_r), .p(pe));
  mrpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_cf (
    .clk(clk), .en(adv), .a(pf), .b(cf), .p(pfc));
  mrpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_ce (
    .clk(clk), .en(adv), .a(pe), .b(ce), .p(pec));
  mrpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_fk (
    .clk(clk), .en(adv), .a(pfc), .b(spring_k64), .p(fk));
  mrpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_ek (
    .clk(clk), .en(adv), .a(pec), .b(spring_k64), .p(ek));
  mrpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_fm (
    .clk(clk), .en(adv), .a(fk), .b(r2_d[5*L+1]), .p(fm));
  mrpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_fx (
    .clk(clk), .en(adv), .a(64'(side[FM_STG].dx)), .b(fm), .p(fx));
  mrpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_fy (
    .clk(clk), .en(adv), .a(64'(side[FM_STG].dy)), .b(fm), .p(fy));
  mrpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_fz (
    .clk(clk), .en(adv), .a(64'(side[FM_STG].dz)), .b(fm), .p(fz));

  always_ff @(posedge clk) begin
    if (adv) begin
      out_index_i <= side[FRC_STG].idx_i;
      out_index_j <= side[FRC_STG].idx_j;
      in_range    <= side[FRC_STG].in_range;
      force_x     <= side[FRC_STG].in_range ? sat32(fx) : '0;
      force_y     <= side[FRC_STG].in_range ? sat32(fy) : '0;
      force_z     <= side[FRC_STG].in_range ? sat32(fz) : '0;
      pair_energy <= side[FRC_STG].in_range ? sat32(en_d[2*L]) : '0;
    end
  end

`ifndef SYNTH
  // A pair beyond the cutoff must leave with all results cleared.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |->
      force_x == '0 && force_y == '0 && force_z == '0 && pair_energy == '0)
    else $error("out-of-range pair produced a nonzero result");

  // The divider remainder of an in-range pair stays below the divisor.
  assert property (@(posedge clk) disable iff (rst)
    vld[DIV_OUT] && side[DIV_OUT].in_range |->
      rs[NUM_W] < d_q[NUM_W] && rr[NUM_W] < d_q[NUM_W])
    else $error("divider remainder not below divisor");

  // While the output is held, no valid bit in the pipeline moves.
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline advanced while stalled");
`endif

endmodule
`default_nettype wire

/* tb/sv/mrpf_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Mie repulsive pair force: result checker
// Watches the pair, force and register channels, predicts the force word for
// every accepted pair and compares each returned word with the oldest one.
// ----------------------------------------------------------------------------
module mrpf_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [15:0]        index_i,
  input  logic [15:0]        index_j,
  input  logic signed [31:0] pos_i_x,
  input  logic signed [31:0] pos_i_y,
  input  logic signed [31:0] pos_i_z,
  input  logic signed [31:0] pos_j_x,
  input  logic signed [31:0] pos_j_y,
  input  logic signed [31:0] pos_j_z,
  input  logic [31:0]        sigma_sq,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        out_index_i,
  input  logic [15:0]        out_index_j,
  input  logic signed [31:0] force_x,
  input  logic signed [31:0] force_y,
  input  logic signed [31:0] force_z,
  input  logic signed [31:0] pair_energy,
  input  logic               in_range,
  output int                 fail_count,
  output int                 pending
);
  import mrpf_pkg::*;

  localparam int FB = 16;
  localparam logic signed [63:0] WIDE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FB;

  typedef struct {
    logic [15:0]        idx_i;
    logic [15:0]        idx_j;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic signed [31:0] energy;
    logic               near;
  } force_word_t;

  force_word_t       force_words_q[$];
  kind_t             kind_r;
  logic [31:0]       cutoff_r;
  logic [31:0]       spring_r;

  function automatic logic signed [63:0] round_const(input logic [31:0] c);
    logic [63:0] w;
    begin
      w = ({32'b0, c} + (64'd1 << (31 - FB))) >> (32 - FB);
      return w;
    end
  endfunction

  function automatic logic signed [63:0] fix_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [127:0] ma, mb, prod;
    logic [63:0]  na, nb;
    begin
      na = a[63] ? -a : a;
      nb = b[63] ? -b : b;
      ma = {64'b0, na};
      mb = {64'b0, nb};
      prod = (ma * mb) >> FB;
      if (prod > {64'b0, WIDE_MAX}) prod = {64'b0, WIDE_MAX};
      return (a[63] ^ b[63]) ? -$signed(prod[63:0]) : $signed(prod[63:0]);
    end
  endfunction

  function automatic logic signed [63:0] fix_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    begin
      s = $signed({a[63], a}) + $signed({b[63], b});
      if (s > $signed({1'b0, WIDE_MAX})) return WIDE_MAX;
      if (s < -$signed({1'b0, WIDE_MAX})) return -WIDE_MAX;
      return s[63:0];
    end
  endfunction

  function automatic logic signed [31:0] clamp_word(input logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    end
  endfunction

  function automatic force_word_t predict_force();
    force_word_t        w;
    logic signed [32:0] d [3];
    logic signed [63:0] dw [3];
    logic [31:0]        m;
    logic [65:0]        acc;
    logic [63:0]        rsq, rsq_q;
    logic signed [63:0] s, r2inv, pf, pe, cf, ce, q, fm, en, k;
    begin
      d[0] = {pos_i_x[31], pos_i_x} - {pos_j_x[31], pos_j_x};
      d[1] = {pos_i_y[31], pos_i_y} - {pos_j_y[31], pos_j_y};
      d[2] = {pos_i_z[31], pos_i_z} - {pos_j_z[31], pos_j_z};
      acc = '0;
      for (int c = 0; c < 3; c++) begin
        dw[c] = {{31{d[c][32]}}, d[c]};
        m = d[c][32] ? 32'(-d[c]) : 32'(d[c]);
        acc = acc + {34'b0, m} * {34'b0, m};
      end
      rsq = (acc > 66'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
      w.idx_i = index_i;
      w.idx_j = index_j;
      w.fx = '0;
      w.fy = '0;
      w.fz = '0;
      w.energy = '0;
      w.near = 1'b0;
      if (rsq > ({32'b0, cutoff_r} << FB)) return w;
      rsq_q = rsq >> FB;
      if (rsq_q == 0) rsq_q = 1;
      s = ({32'b0, sigma_sq} << FB) / rsq_q;
      r2inv = (64'd1 << (2 * FB)) / rsq_q;
      k = {32'b0, spring_r};
      case (kind_r)
        KIND_MIE_4_2: begin
          pf = fix_mul(s, fix_add(fix_mul(s, 4 * ONE_Q), -2 * ONE_Q));
          pe = fix_mul(s, fix_add(s, -ONE_Q));
          cf = round_const(C_F42);
          ce = cf;
        end
        KIND_MIE_6_2: begin
          q = fix_mul(s, s);
          pf = fix_mul(s, fix_add(fix_mul(q, 6 * ONE_Q), -2 * ONE_Q));
          pe = fix_mul(s, fix_add(q, -ONE_Q));
          cf = round_const(C_F62);
          ce = cf;
        end
        KIND_MIE_8_4: begin
          q = fix_mul(s, s);
          pf = fix_mul(q, fix_add(fix_mul(q, 2 * ONE_Q), -ONE_Q));
          pe = fix_mul(q, fix_add(q, -ONE_Q));
          cf = round_const(C_F84);
          ce = round_const(C_E84);
        end
        default: begin
          q = fix_mul(fix_mul(s, s), s);
          pf = fix_mul(q, fix_add(fix_mul(q, 2 * ONE_Q), -ONE_Q));
          pe = fix_mul(q, fix_add(q, -ONE_Q));
          cf = round_const(C_F126);
          ce = round_const(C_E126);
        end
      endcase
      fm = fix_mul(fix_mul(fix_mul(pf, cf), k), r2inv);
      en = fix_mul(fix_mul(pe, ce), k);
      w.fx = clamp_word(fix_mul(dw[0], fm));
      w.fy = clamp_word(fix_mul(dw[1], fm));
      w.fz = clamp_word(fix_mul(dw[2], fm));
      w.energy = clamp_word(en);
      w.near = 1'b1;
      return w;
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    force_word_t e;
    if (rst) begin
      kind_r <= KIND_MIE_4_2;
      cutoff_r <= 32'd65536;
      spring_r <= 32'd65536;
    end else begin
      if (in_valid && !in_stall) force_words_q.push_back(predict_force());
      if (out_valid && !out_stall) begin
        if (force_words_q.size() == 0) begin
          $error("force word with no pair waiting");
          fail_count++;
        end else begin
          e = force_words_q.pop_front();
          check_field("out_index_i", 32'(e.idx_i), 32'(out_index_i));
          check_field("out_index_j", 32'(e.idx_j), 32'(out_index_j));
          check_field("force_x", e.fx, force_x);
          check_field("force_y", e.fy, force_y);
          check_field("force_z", e.fz, force_z);
          check_field("pair_energy", e.energy, pair_energy);
          check_field("in_range", 32'(e.near), 32'(in_range));
        end
      end
      if (wr_en) begin
        case (wr_index)
          REG_KIND:   kind_r <= kind_t'(wr_data[1:0]);
          REG_CUTOFF: cutoff_r <= wr_data;
          REG_SPRING: spring_r <= wr_data;
          default: ;
        endcase
      end
    end
    pending = force_words_q.size();
  end

endmodule
`default_nettype wire

/* tb/sv/mie_repulsive_pair_force_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Mie repulsive pair force: testbench top
// Drives directed and random particle pairs through several register
// settings with random gaps and output stalls; the checker scores results.
// ----------------------------------------------------------------------------
module mie_repulsive_pair_force_tb;
  import mrpf_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic               clk;
  logic               rst;
  logic               wr_en;
  logic [1:0]         wr_index;
  logic [31:0]        wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [15:0]        index_i, index_j;
  logic signed [31:0] pos_i_x, pos_i_y, pos_i_z;
  logic signed [31:0] pos_j_x, pos_j_y, pos_j_z;
  logic [31:0]        sigma_sq;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        out_index_i, out_index_j;
  logic signed [31:0] force_x, force_y, force_z, pair_energy;
  logic               in_range;
  int                 fail_count;
  int                 pending;
  int                 cycles;
  logic               no_gaps;

  mie_repulsive_pair_force dut (.*);

  mrpf_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic drain();
    logic busy;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      busy = (pending != 0);
    end while (busy);
    @(posedge clk);
  endtask

  task automatic send_pair(input logic [15:0] ii, input logic [15:0] ij,
                           input logic [31:0] ix, input logic [31:0] iy,
                           input logic [31:0] iz, input logic [31:0] jx,
                           input logic [31:0] jy, input logic [31:0] jz,
                           input logic [31:0] sig);
    int  gap;
    logic taken;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    index_i <= ii;
    index_j <= ij;
    pos_i_x <= ix;
    pos_i_y <= iy;
    pos_i_z <= iz;
    pos_j_x <= jx;
    pos_j_y <= jy;
    pos_j_z <= jz;
    sigma_sq <= sig;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_random_pair();
    logic [31:0] jx, jy, jz, sig;
    int          span;
    int          mode;
    mode = $urandom_range(0, 9);
    jx = $urandom;
    jy = $urandom;
    jz = $urandom;
    sig = $urandom >> $urandom_range(0, 31);
    span = 1 << $urandom_range(2, 19);
    if (mode < 7) begin
      send_pair(16'($urandom), 16'($urandom),
                jx + $urandom_range(0, 2 * span) - span,
                jy + $urandom_range(0, 2 * span) - span,
                jz + $urandom_range(0, 2 * span) - span, jx, jy, jz, sig);
    end else if (mode < 9) begin
      send_pair(16'($urandom), 16'($urandom), $urandom, $urandom, $urandom,
                jx, jy, jz, sig);
    end else begin
      send_pair(16'($urandom), 16'($urandom), jx, jy, jz, jx, jy, jz, sig);
    end
  endtask

  initial begin
    int  n;
    logic taken;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        taken = out_valid;
        @(posedge clk);
      end while (!taken);
    end
  end

  initial begin
    logic [31:0] cut_pick [4];
    logic [31:0] spring_pick [4];
    logic        done;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_KIND;
    wr_data = '0;
    in_valid = 1'b0;
    index_i = '0;
    index_j = '0;
    pos_i_x = '0;
    pos_i_y = '0;
    pos_i_z = '0;
    pos_j_x = '0;
    pos_j_y = '0;
    pos_j_z = '0;
    sigma_sq = '0;
    no_gaps = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: coincident pair, exact cutoff, far pair, field extremes.
    send_pair(16'h0000, 16'hFFFF, 0, 0, 0, 0, 0, 0, 32'h0001_0000);
    send_pair(16'hFFFF, 16'h0000, 32'h0001_0000, 0, 0, 0, 0, 0, 32'h0001_0000);
    send_pair(16'h1234, 16'h4321, 32'h0001_0001, 0, 0, 0, 0, 0, 32'h0001_0000);
    send_pair(16'hA5A5, 16'h5A5A, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_pair(16'd1, 16'd2, 32'h0000_8000, 32'hFFFF_8000, 0, 0, 0, 0, 0);
    send_pair(16'd3, 16'd4, 32'h0000_0100, 0, 32'hFFFF_FF00, 0, 0, 0, 32'hFFFF_FFFF);
    send_pair(16'd5, 16'd6, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_pair(16'd7, 16'd8, 1, 1, 1, 0, 0, 0, 32'h0000_0001);
    drain();

    write_reg(2'd3, 32'hFFFF_FFFF);
    write_reg(REG_CUTOFF, 32'hFFFF_FFFF);
    write_reg(REG_SPRING, 32'hFFFF_FFFF);
    for (int kd = 0; kd < 4; kd++) begin
      write_reg(REG_KIND, kd);
      send_pair(16'd9, 16'd10, 32'h0000_C000, 32'h0000_4000, 0, 0, 0, 0,
                32'h0001_0000);
      send_pair(16'd11, 16'd12, 32'h0000_0010, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
      send_pair(16'd13, 16'd14, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0,
                32'h0001_0000);
      send_pair(16'd15, 16'd16, 32'h0002_0000, 32'h0002_0000, 0, 0, 0, 0,
                32'h0000_0000);
      drain();
    end

    cut_pick[0] = 32'hFFFF_FFFF;
    cut_pick[1] = 32'h0000_0000;
    cut_pick[2] = 32'h0004_0000;
    spring_pick[0] = 32'h0000_0000;
    spring_pick[1] = 32'h0001_0000;
    spring_pick[2] = 32'hFFFF_FFFF;
    for (int ph = 0; ph < 8; ph++) begin
      cut_pick[3] = $urandom;
      spring_pick[3] = $urandom >> $urandom_range(0, 24);
      write_reg(REG_KIND, ph % 4);
      write_reg(REG_CUTOFF, (ph == 1) ? 32'h0000_0000 : cut_pick[$urandom_range(0, 3)]);
      write_reg(REG_SPRING, spring_pick[(ph + $urandom_range(0, 1)) % 4]);
      no_gaps = (ph == 5);
      for (int it = 0; it < 110; it++) send_random_pair();
      drain();
    end
    no_gaps = 1'b0;
    in_valid <= 1'b0;

    do begin
      @(negedge clk);
      done = (pending == 0);
    end while (!done);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
